// ===== rtl/irs_pkg.sv =====
// Shared types, constants and header byte builder for the image report segmenter.
// No dependencies; used by every module under rtl/.
package irs_pkg;

    localparam int MAX_REPORT_BYTES_DEF = 8191;
    localparam int LENGTH_BITS_DEF      = 24;
    localparam int QUEUE_DEPTH          = 4;
    localparam int MIN_REPORT_LENGTH    = 17;
    localparam int HDR_LEN_LONG         = 16;
    localparam int HDR_LEN_SHORT        = 8;

    localparam logic [1:0]  RST_HEADER_MODE   = 2'd1;
    localparam logic [12:0] RST_REPORT_LENGTH = 13'd1024;
    localparam logic [7:0]  RST_NUM_KEYS      = 8'd15;
    localparam logic [15:0] RST_TOUCH_LIMIT   = 16'd800;

    localparam logic [7:0] REPORT_ID  = 8'h02;
    localparam logic [7:0] CMD_KEY_V1 = 8'h01;
    localparam logic [7:0] CMD_KEY_V2 = 8'h07;
    localparam logic [7:0] CMD_TOUCH  = 8'h0c;

    typedef enum logic [1:0] {
        MODE_KEY_V1 = 2'd0,
        MODE_KEY_V2 = 2'd1,
        MODE_TOUCH  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_HEADER_MODE   = 2'd0,
        REG_REPORT_LENGTH = 2'd1,
        REG_NUM_KEYS      = 2'd2,
        REG_TOUCH_LIMIT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  header_mode;
        logic [12:0] report_length;
        logic [7:0]  num_keys;
        logic [15:0] touch_limit;
    } t_cfg;

    // One queue entry: an error, or one payload byte with an optional header ahead of it
    typedef struct packed {
        logic        err;
        logic        hdr;
        t_mode       mode;
        logic        last;
        logic [15:0] page;
        logic [15:0] target;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] len;
        logic [7:0]  data;
        logic        rend;
        logic        iend;
        logic [12:0] fill;
    } t_cmd;

    function automatic logic hdr_long(t_mode m);
        return (m != MODE_KEY_V2);
    endfunction

    function automatic logic [7:0] hdr_byte(t_cmd c, logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (c.mode)
            MODE_KEY_V1: begin
                case (idx)
                    4'd0:    b = REPORT_ID;
                    4'd1:    b = CMD_KEY_V1;
                    4'd2:    b = c.page[7:0] + 8'd1;
                    4'd4:    b = {7'd0, c.last};
                    4'd5:    b = c.target[7:0] + 8'd1;
                    default: b = 8'h00;
                endcase
            end
            MODE_TOUCH: begin
                case (idx)
                    4'd0:    b = REPORT_ID;
                    4'd1:    b = CMD_TOUCH;
                    4'd2:    b = c.target[7:0];
                    4'd3:    b = c.target[15:8];
                    4'd6:    b = c.width[7:0];
                    4'd7:    b = c.width[15:8];
                    4'd8:    b = c.height[7:0];
                    4'd9:    b = c.height[15:8];
                    4'd10:   b = {7'd0, c.last};
                    4'd11:   b = c.page[7:0];
                    4'd12:   b = c.page[15:8];
                    4'd13:   b = c.len[7:0];
                    4'd14:   b = c.len[15:8];
                    default: b = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    4'd0:    b = REPORT_ID;
                    4'd1:    b = CMD_KEY_V2;
                    4'd2:    b = c.target[7:0];
                    4'd3:    b = {7'd0, c.last};
                    4'd4:    b = c.len[7:0];
                    4'd5:    b = c.len[15:8];
                    4'd6:    b = c.page[7:0];
                    4'd7:    b = c.page[15:8];
                    default: b = 8'h00;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/irs_front.sv =====
// Front end: accepts image bytes, tracks image/report position, checks targets.
// Depends on irs_pkg; pushes one command per byte that yields output into irs_queue.
module irs_front import irs_pkg::*; #(
    parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF,
    parameter int LENGTH_BITS      = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_image_start,
    input  logic [23:0] i_image_length,
    input  logic [15:0] i_target_index,
    input  logic [15:0] i_image_width,
    input  logic [15:0] i_image_height,
    input  logic        i_q_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam int FILL_W = $clog2(MAX_REPORT_BYTES + 1);
    localparam int CMP_W  = (LENGTH_BITS > FILL_W) ? LENGTH_BITS : FILL_W;

    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [15:0]            r_page, n_page;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic                   r_drop, n_drop;
    logic [15:0]            r_target, n_target;
    logic [15:0]            r_width, n_width;
    logic [15:0]            r_height, n_height;

    logic                   accept;
    t_mode                  mode;
    logic [31:0]            rl32;
    logic [31:0]            len32;
    logic [FILL_W-1:0]      rl;
    logic [FILL_W-1:0]      hs;
    logic [FILL_W-1:0]      pay;
    logic                   bad;
    logic                   err;
    logic [LENGTH_BITS-1:0] cur_rem;
    logic [LENGTH_BITS-1:0] rem_after;
    logic [FILL_W-1:0]      cur_fill;
    logic [FILL_W-1:0]      fill_after;
    logic                   active;
    logic                   last;
    logic                   rend;
    logic                   iend;
    logic [CMP_W-1:0]       len_w;

    assign accept  = i_valid && i_q_ready;
    assign o_ready = i_q_ready;

    always_comb begin
        case (i_cfg.header_mode)
            2'd0:    mode = MODE_KEY_V1;
            2'd2:    mode = MODE_TOUCH;
            default: mode = MODE_KEY_V2;
        endcase

        rl32 = {19'd0, i_cfg.report_length};
        if (rl32 < 32'(MIN_REPORT_LENGTH)) begin
            rl32 = 32'(MIN_REPORT_LENGTH);
        end
        if (rl32 > 32'(MAX_REPORT_BYTES)) begin
            rl32 = 32'(MAX_REPORT_BYTES);
        end
        rl  = rl32[FILL_W-1:0];
        hs  = hdr_long(mode) ? FILL_W'(HDR_LEN_LONG) : FILL_W'(HDR_LEN_SHORT);
        pay = rl - hs;

        len32 = {8'd0, i_image_length};
        if (mode == MODE_TOUCH) begin
            bad = i_target_index >= i_cfg.touch_limit;
        end else begin
            bad = i_target_index >= {8'd0, i_cfg.num_keys};
        end
        err = i_image_start && bad;

        if (i_image_start) begin
            cur_rem  = bad ? '0 : len32[LENGTH_BITS-1:0];
            cur_fill = '0;
            n_page   = 16'd0;
            n_drop   = bad;
            n_target = i_target_index;
            n_width  = i_image_width;
            n_height = i_image_height;
        end else begin
            cur_rem  = r_rem;
            cur_fill = r_fill;
            n_page   = r_page;
            n_drop   = r_drop;
            n_target = r_target;
            n_width  = r_width;
            n_height = r_height;
        end

        active     = !n_drop && (cur_rem != '0);
        last       = CMP_W'(cur_rem) <= CMP_W'(pay);
        len_w      = last ? CMP_W'(cur_rem) : CMP_W'(pay);
        fill_after = ((cur_fill == '0) ? hs : cur_fill) + FILL_W'(1);
        rem_after  = cur_rem - LENGTH_BITS'(1);
        iend       = (rem_after == '0);
        rend       = iend || (fill_after >= rl);

        n_rem  = cur_rem;
        n_fill = cur_fill;
        if (active) begin
            n_rem  = rem_after;
            n_fill = rend ? '0 : fill_after;
            if (rend) begin
                n_page = n_page + 16'd1;
            end
        end

        o_push        = accept && (err || active);
        o_cmd.err     = err;
        o_cmd.hdr     = (cur_fill == '0);
        o_cmd.mode    = mode;
        o_cmd.last    = last;
        o_cmd.target  = n_target;
        o_cmd.width   = n_width;
        o_cmd.height  = n_height;
        o_cmd.len     = 16'(len_w);
        o_cmd.data    = i_data_byte;
        o_cmd.rend    = rend;
        o_cmd.iend    = iend;
        o_cmd.fill    = (iend && (fill_after < rl)) ? 13'(rl - fill_after) : 13'd0;
        // header page is the page before any increment
        o_cmd.page    = i_image_start ? 16'd0 : r_page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_page   <= '0;
            r_fill   <= '0;
            r_drop   <= 1'b0;
            r_target <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (accept) begin
            r_rem    <= n_rem;
            r_page   <= n_page;
            r_fill   <= n_fill;
            r_drop   <= n_drop;
            r_target <= n_target;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

endmodule

// ===== rtl/irs_queue.sv =====
// Short command queue between front and back ends.
// Depends on irs_pkg for the command type and depth.
module irs_queue import irs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/irs_back.sv =====
// Back end: expands each queued command into header bytes and the payload byte, or an error request.
// Depends on irs_pkg; drives the registered output stage of the block.
module irs_back import irs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_report_byte,
    output logic        o_report_end,
    output logic        o_image_end,
    output logic [12:0] o_zero_fill_count,
    output logic        o_target_error
);

    logic        r_out_valid;
    logic [3:0]  r_idx;
    logic        r_hdr_done;
    logic [7:0]  r_byte;
    logic        r_rend;
    logic        r_iend;
    logic [12:0] r_zfill;
    logic        r_err;

    logic        free;
    logic        take;
    logic        emit_hdr;
    logic        last_hdr;

    assign free     = !r_out_valid || i_ready;
    assign take     = free && i_q_valid;
    assign emit_hdr = i_cmd.hdr && !r_hdr_done && !i_cmd.err;
    assign last_hdr = r_idx == (hdr_long(i_cmd.mode) ? 4'(HDR_LEN_LONG - 1)
                                                      : 4'(HDR_LEN_SHORT - 1));
    assign o_pop    = take && !emit_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_hdr_done  <= 1'b0;
        end else begin
            if (free) begin
                r_out_valid <= i_q_valid;
            end
            if (take) begin
                if (emit_hdr) begin
                    r_idx      <= last_hdr ? 4'd0 : r_idx + 4'd1;
                    r_hdr_done <= last_hdr;
                end else begin
                    r_idx      <= '0;
                    r_hdr_done <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (i_cmd.err) begin
                r_byte  <= 8'd0;
                r_rend  <= 1'b0;
                r_iend  <= 1'b0;
                r_zfill <= 13'd0;
                r_err   <= 1'b1;
            end else if (emit_hdr) begin
                r_byte  <= hdr_byte(i_cmd, r_idx);
                r_rend  <= 1'b0;
                r_iend  <= 1'b0;
                r_zfill <= 13'd0;
                r_err   <= 1'b0;
            end else begin
                r_byte  <= i_cmd.data;
                r_rend  <= i_cmd.rend;
                r_iend  <= i_cmd.iend;
                r_zfill <= i_cmd.fill;
                r_err   <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_report_byte     = r_byte;
    assign o_report_end      = r_rend;
    assign o_image_end       = r_iend;
    assign o_zero_fill_count = r_zfill;
    assign o_target_error    = r_err;

endmodule

// ===== rtl/image_report_segmenter.sv =====
// Image report segmenter top level: APB registers, front end, queue, back end.
// Depends on irs_pkg, irs_front, irs_queue, irs_back.
//
// Input stream (s side): one image byte per request; tuser flags the first byte
// of an image, tdata carries the byte plus image length, target and size.
// Output stream (m side): one report byte per request; tlast marks the last byte
// of a report, tuser flags a rejected target (one such request per bad image).
// The last byte of an image carries the count of zero bytes the sender appends.
// Path: an accepted payload byte is written into the queue, then into the
// output register; a byte that opens a report is preceded by 8 or 16 header
// bytes, one per cycle while the receiver is ready.
// Throughput: one byte per cycle inside a report while the receiver is ready;
// a report's first byte waits for its header in the single-byte output stage.
// A 4-entry command queue lets input keep flowing while headers go out.
// Reset: registers return to defaults (mode 1, length 1024, 15 keys, offset
// limit 800), position state clears, queue and output stage empty.
// Stall: the output register holds its request; the queue fills and then
// o_s_tready drops until the receiver takes data again.
// Registers (APB, byte address 4*i): header_mode, report_length, number of keys,
// touch_offset_limit. pready is always high.
module image_report_segmenter import irs_pkg::*; #(
    parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF,
    parameter int LENGTH_BITS      = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] data_byte, [31:8] image_length, [47:32] target_index,
    // [63:48] image_width, [79:64] image_height
    input  logic [79:0] i_s_tdata,
    // [0] image_start
    input  logic        i_s_tuser,
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] report_byte, [8] image_end, [21:9] zero_fill_count, [23:22] zero
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast,
    // [0] target_error
    output logic        o_m_tuser
);

    t_cfg        r_cfg;
    logic        cfg_wr;
    t_reg_idx    reg_idx;

    logic        q_ready;
    logic        push;
    t_cmd        push_cmd;
    logic        q_valid;
    t_cmd        head_cmd;
    logic        pop;

    logic [7:0]  report_byte;
    logic        image_end;
    logic [12:0] zero_fill;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign reg_idx  = t_reg_idx'(i_paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mode   <= RST_HEADER_MODE;
            r_cfg.report_length <= RST_REPORT_LENGTH;
            r_cfg.num_keys      <= RST_NUM_KEYS;
            r_cfg.touch_limit   <= RST_TOUCH_LIMIT;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_HEADER_MODE:   r_cfg.header_mode   <= i_pwdata[1:0];
                REG_REPORT_LENGTH: r_cfg.report_length <= i_pwdata[12:0];
                REG_NUM_KEYS:      r_cfg.num_keys      <= i_pwdata[7:0];
                REG_TOUCH_LIMIT:   r_cfg.touch_limit   <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEADER_MODE:   o_prdata = {30'd0, r_cfg.header_mode};
            REG_REPORT_LENGTH: o_prdata = {19'd0, r_cfg.report_length};
            REG_NUM_KEYS:      o_prdata = {24'd0, r_cfg.num_keys};
            REG_TOUCH_LIMIT:   o_prdata = {16'd0, r_cfg.touch_limit};
            default:           o_prdata = 32'd0;
        endcase
    end

    irs_front #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES),
        .LENGTH_BITS      (LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_data_byte    (i_s_tdata[7:0]),
        .i_image_start  (i_s_tuser),
        .i_image_length (i_s_tdata[31:8]),
        .i_target_index (i_s_tdata[47:32]),
        .i_image_width  (i_s_tdata[63:48]),
        .i_image_height (i_s_tdata[79:64]),
        .i_q_ready      (q_ready),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    irs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    irs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_cmd             (head_cmd),
        .o_pop             (pop),
        .o_valid           (o_m_tvalid),
        .i_ready           (i_m_tready),
        .o_report_byte     (report_byte),
        .o_report_end      (o_m_tlast),
        .o_image_end       (image_end),
        .o_zero_fill_count (zero_fill),
        .o_target_error    (o_m_tuser)
    );

    assign o_m_tdata = {2'b00, zero_fill, image_end, report_byte};

    // error requests carry nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata == 24'd0) && !o_m_tlast)
        else $error("target error request carries data");

    // the end of an image always closes its report
    a_iend_rend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> o_m_tlast)
        else $error("image end without report end");

    // zero fill only on the last byte of an image
    a_fill_iend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[21:9] != 13'd0) |-> o_m_tdata[8])
        else $error("zero fill outside image end");

    // the queue never takes a push while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready)
        else $error("command queue overflow");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for image_report_segmenter: APB register setup, image byte
// stream in, report byte stream out, checked against a scoreboard with its own predictor.
// Depends on irs_pkg and the image_report_segmenter RTL.
`timescale 1ns / 100ps

module tb;
    import irs_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BYTES = 240;
    localparam int PHASE_BYTES  = 22;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic [23:0] length;
        logic [15:0] target;
        logic [15:0] wd;
        logic [15:0] ht;
    } t_image_in;

    typedef struct packed {
        logic [7:0]  rbyte;
        logic        rend;
        logic        iend;
        logic [12:0] zfill;
        logic        terr;
    } t_report_out;

    // Tracks register settings and segmenter position; queues the report bytes owed.
    class report_scoreboard;
        logic [1:0]  mode;
        logic [12:0] rlen;
        logic [7:0]  keys;
        logic [15:0] tlimit;
        int          remaining;
        int          fill_cnt;
        logic [15:0] page;
        logic [15:0] tgt_q;
        logic [15:0] wd_q;
        logic [15:0] ht_q;
        bit          dropping;
        t_report_out pending[$];
        int          mismatches;
        int          checked;

        function new();
            mode       = RST_HEADER_MODE;
            rlen       = RST_REPORT_LENGTH;
            keys       = RST_NUM_KEYS;
            tlimit     = RST_TOUCH_LIMIT;
            remaining  = 0;
            fill_cnt   = 0;
            page       = '0;
            tgt_q      = '0;
            wd_q       = '0;
            ht_q       = '0;
            dropping   = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_HEADER_MODE:   mode   = v[1:0];
                REG_REPORT_LENGTH: rlen   = v[12:0];
                REG_NUM_KEYS:      keys   = v[7:0];
                REG_TOUCH_LIMIT:   tlimit = v[15:0];
                default: ;
            endcase
        endfunction

        function int eff_length();
            return (rlen < MIN_REPORT_LENGTH) ? MIN_REPORT_LENGTH : int'(rlen);
        endfunction

        function int hdr_size();
            return (mode == MODE_KEY_V1 || mode == MODE_TOUCH) ? HDR_LEN_LONG : HDR_LEN_SHORT;
        endfunction

        // Returns how many report bytes this input request causes.
        function int note_input(t_image_in it);
            int          rl;
            int          hs;
            int          p;
            int          n;
            bit          reject;
            logic        last;
            logic [15:0] lenv;
            logic [7:0]  hdr [16];
            n  = 0;
            rl = eff_length();
            if (it.first) begin
                tgt_q     = it.target;
                wd_q      = it.wd;
                ht_q      = it.ht;
                remaining = int'(it.length);
                page      = '0;
                fill_cnt  = 0;
                dropping  = 1'b0;
                reject = (mode == MODE_TOUCH) ? (tgt_q >= tlimit) : (tgt_q >= {8'd0, keys});
                if (reject) begin
                    dropping  = 1'b1;
                    remaining = 0;
                    pending.push_back('{8'h00, 1'b0, 1'b0, 13'd0, 1'b1});
                    return 1;
                end
            end
            if (dropping || remaining == 0)
                return 0;
            if (fill_cnt == 0) begin
                hs   = hdr_size();
                p    = rl - hs;
                last = (remaining <= p);
                lenv = last ? remaining[15:0] : p[15:0];
                for (int i = 0; i < 16; i++)
                    hdr[i] = 8'h00;
                hdr[0] = REPORT_ID;
                case (mode)
                    MODE_KEY_V1: begin
                        hdr[1] = CMD_KEY_V1;
                        hdr[2] = page[7:0] + 8'd1;
                        hdr[4] = {7'd0, last};
                        hdr[5] = tgt_q[7:0] + 8'd1;
                    end
                    MODE_TOUCH: begin
                        hdr[1]  = CMD_TOUCH;
                        hdr[2]  = tgt_q[7:0];
                        hdr[3]  = tgt_q[15:8];
                        hdr[6]  = wd_q[7:0];
                        hdr[7]  = wd_q[15:8];
                        hdr[8]  = ht_q[7:0];
                        hdr[9]  = ht_q[15:8];
                        hdr[10] = {7'd0, last};
                        hdr[11] = page[7:0];
                        hdr[12] = page[15:8];
                        hdr[13] = lenv[7:0];
                        hdr[14] = lenv[15:8];
                    end
                    default: begin
                        // mode 3 falls back to the short key header
                        hdr[1] = CMD_KEY_V2;
                        hdr[2] = tgt_q[7:0];
                        hdr[3] = {7'd0, last};
                        hdr[4] = lenv[7:0];
                        hdr[5] = lenv[15:8];
                        hdr[6] = page[7:0];
                        hdr[7] = page[15:8];
                    end
                endcase
                for (int i = 0; i < hs; i++)
                    pending.push_back('{hdr[i], 1'b0, 1'b0, 13'd0, 1'b0});
                n        = hs;
                fill_cnt = hs;
            end
            fill_cnt++;
            remaining--;
            if (remaining == 0) begin
                pending.push_back('{it.data, 1'b1, 1'b1,
                                    13'((fill_cnt < rl) ? rl - fill_cnt : 0), 1'b0});
                fill_cnt = 0;
                page     = page + 16'd1;
            end else if (fill_cnt >= rl) begin
                pending.push_back('{it.data, 1'b1, 1'b0, 13'd0, 1'b0});
                fill_cnt = 0;
                page     = page + 16'd1;
            end else begin
                pending.push_back('{it.data, 1'b0, 1'b0, 13'd0, 1'b0});
            end
            return n + 1;
        endfunction

        function void check_result(t_report_out got);
            t_report_out exp_r;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected report byte %02h tlast %0d iend %0d fill %0d err %0d",
                             got.rbyte, got.rend, got.iend, got.zfill, got.terr);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("mismatch: exp byte %02h tlast %0d iend %0d fill %0d err %0d",
                             exp_r.rbyte, exp_r.rend, exp_r.iend, exp_r.zfill, exp_r.terr);
                    $display("          got byte %02h tlast %0d iend %0d fill %0d err %0d",
                             got.rbyte, got.rend, got.iend, got.zfill, got.terr);
                end
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_psel     = 1'b0;
    logic        i_penable  = 1'b0;
    logic        i_pwrite   = 1'b0;
    logic [3:0]  i_paddr    = '0;
    logic [31:0] i_pwdata   = '0;
    logic [31:0] o_prdata;
    logic        o_pready;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata  = '0;
    logic        i_s_tuser  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    report_scoreboard sb;
    int cycles         = 0;
    int rx_style       = 0;
    int tx_style       = 0;
    int rx_hold        = 0;
    int burst_left     = 0;
    int bytes_driven   = 0;
    int bytes_answered = 0;
    int settings_seen  = 0;

    image_report_segmenter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("timeout with %0d report bytes outstanding", sb.pending.size());
            $display("image_report_segmenter test failed");
            $finish;
        end
    end

    // receiver: 0 always ready, 1 short frequent stalls, 2 rare long stalls
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (rx_style == 1 && $urandom_range(0, 3) == 0) begin
            rx_hold    <= $urandom_range(0, 2);
            i_m_tready <= 1'b0;
        end else if (rx_style == 2 && $urandom_range(0, 15) == 0) begin
            rx_hold    <= $urandom_range(3, 12);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result('{o_m_tdata[7:0], o_m_tlast, o_m_tdata[8], o_m_tdata[21:9],
                              o_m_tuser});
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= v;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        sb.set_reg(idx, v);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Holds the input side idle until every owed report byte is out, then lets
    // stray requests still in the pipe drain.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [1:0] mode, logic [12:0] rl, logic [7:0] keys,
                              logic [15:0] lim);
        settle();
        write_reg(REG_HEADER_MODE, {30'd0, mode});
        write_reg(REG_REPORT_LENGTH, {19'd0, rl});
        write_reg(REG_NUM_KEYS, {24'd0, keys});
        write_reg(REG_TOUCH_LIMIT, {16'd0, lim});
        settings_seen++;
    endtask

    task automatic send_byte(logic [7:0] data, logic first, logic [23:0] length,
                             logic [15:0] target, logic [15:0] wd, logic [15:0] ht);
        t_image_in it;
        int        gap;
        it         = '{data, first, length, target, wd, ht};
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ht, wd, target, length, data};
        i_s_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_driven++;
        if (sb.note_input(it) > 0)
            bytes_answered++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap = (tx_style == 0) ? 0 : $urandom_range(0, (tx_style == 1) ? 3 : 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_image(logic [23:0] length, int nbytes, logic [15:0] target,
                              logic [15:0] wd, logic [15:0] ht);
        for (int i = 0; i < nbytes; i++)
            send_byte(8'($urandom_range(0, 255)), i == 0, length, target, wd, ht);
    endtask

    // Mostly well-formed images; the rest rejected targets, abandoned and empty
    // images, and bytes outside any image.
    task automatic random_image();
        int          p;
        int          kind;
        int          len;
        logic [15:0] lim;
        logic [15:0] tgt;
        p    = sb.eff_length() - sb.hdr_size();
        lim  = (sb.mode == MODE_TOUCH) ? sb.tlimit : {8'd0, sb.keys};
        kind = $urandom_range(0, 99);
        tgt  = (lim == 0) ? 16'd0 : 16'($urandom_range(0, lim - 1));
        if (kind < 70 && lim != 0) begin
            case ($urandom_range(0, 3))
                0:       len = p;
                1:       len = p + 1;
                default: len = $urandom_range(1, 3 * p);
            endcase
            if (len > 60)
                len = $urandom_range(1, 60);
            send_image(24'(len), len, tgt, 16'($urandom), 16'($urandom));
        end else if (kind < 80) begin
            send_image(24'($urandom_range(1, 24'hFFFFFF)), $urandom_range(1, 3),
                       16'($urandom_range(lim, 16'hFFFF)), 16'($urandom), 16'($urandom));
        end else if (kind < 88) begin
            send_image(24'($urandom_range(61, 24'hFFFFFF)), $urandom_range(1, 8), tgt,
                       16'($urandom), 16'($urandom));
        end else if (kind < 94) begin
            send_image(24'd0, $urandom_range(1, 2), tgt, 16'($urandom), 16'($urandom));
        end else begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, 24'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int ph;
        int base;
        int phase_base;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(MODE_KEY_V2, 13'd17, 8'd15, 16'd800);
        send_byte(8'hFF, 1'b1, 24'd1, 16'd14, 16'h0000, 16'h0000);  // highest legal key
        send_byte(8'h5A, 1'b1, 24'd3, 16'd15, 16'hFFFF, 16'hFFFF);  // key out of range
        send_byte(8'h00, 1'b0, 24'd3, 16'd15, 16'hFFFF, 16'hFFFF);
        send_byte(8'h11, 1'b1, 24'd0, 16'd2, 16'h0000, 16'h0000);   // empty image
        send_byte(8'h22, 1'b0, 24'd0, 16'd2, 16'h0000, 16'h0000);   // stray byte
        send_image(24'hFFFFFF, 2, 16'd3, 16'hFFFF, 16'h0000);       // abandoned by restart
        send_image(24'd1, 1, 16'd4, 16'h0000, 16'hFFFF);
        set_config(MODE_KEY_V1, 13'd17, 8'd255, 16'd800);
        send_image(24'd2, 2, 16'd254, 16'h0000, 16'h0000);
        set_config(MODE_TOUCH, 13'd40, 8'd255, 16'd65535);
        send_image(24'd3, 3, 16'd65534, 16'hFFFF, 16'hFFFF);
        send_byte(8'h33, 1'b1, 24'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_config(2'd3, 13'd0, 8'd1, 16'd1);
        send_image(24'd1, 1, 16'd0, 16'h1234, 16'h5678);
        set_config(MODE_KEY_V1, 13'd17, 8'd0, 16'd1);
        send_image(24'd1, 1, 16'd0, 16'h0000, 16'h0000);
        // shrink the report length under the current fill in the middle of an image
        set_config(MODE_KEY_V2, 13'd24, 8'd15, 16'd800);
        send_image(24'd12, 10, 16'd5, 16'h0000, 16'h0000);
        settle();
        write_reg(REG_REPORT_LENGTH, 32'd17);
        send_byte(8'hA5, 1'b0, 24'd12, 16'd5, 16'h0000, 16'h0000);
        send_byte(8'h5A, 1'b0, 24'd12, 16'd5, 16'h0000, 16'h0000);

        base = bytes_answered;
        ph   = 0;
        while (bytes_answered - base < RANDOM_BYTES) begin
            case (ph % 8)
                0: set_config(MODE_KEY_V2, 13'd17, 8'($urandom_range(1, 255)),
                              16'($urandom));
                1: set_config(MODE_KEY_V1, 13'd0, 8'($urandom_range(1, 255)),
                              16'($urandom));
                2: set_config(MODE_TOUCH, 13'd8191, 8'($urandom_range(1, 255)), 16'd1);
                3: set_config(2'd3, 13'($urandom_range(17, 64)), 8'd1, 16'($urandom));
                4: set_config(MODE_TOUCH, 13'($urandom_range(17, 64)), 8'($urandom),
                              16'd65535);
                5: set_config(MODE_KEY_V1, 13'($urandom_range(20, 100)), 8'd255,
                              16'($urandom));
                6: set_config(MODE_KEY_V2, 13'd8191, 8'($urandom_range(1, 255)),
                              16'($urandom));
                default: set_config(2'($urandom_range(0, 3)), 13'($urandom_range(0, 200)),
                                    8'($urandom_range(1, 255)),
                                    16'($urandom_range(1, 65535)));
            endcase
            rx_style   = ph % 3;
            tx_style   = (ph + 1) % 3;
            phase_base = bytes_answered;
            while (bytes_answered - phase_base < PHASE_BYTES)
                random_image();
            ph++;
        end
        settle();

        $display("%0d image bytes driven (%0d answered), %0d report bytes checked",
                 bytes_driven, bytes_answered, sb.checked);
        $display("%0d register settings, %0d mismatches, %0d report bytes never seen",
                 settings_seen, sb.mismatches, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("image_report_segmenter test passed");
        else
            $display("image_report_segmenter test failed");
        $finish;
    end

endmodule
